FILE: hdl/mccq_pkg.sv
// Shared types, constants and helpers of the min-cost cover block.
// Holds the microcode ROM, the step encoding and the saturating cost add.
// No dependencies.
package mccq_pkg;

  localparam int QUANTITY_LIMIT = 256;
  localparam int MAX_BUNDLES    = 32;

  localparam int QA_W  = (QUANTITY_LIMIT > 1) ? $clog2(QUANTITY_LIMIT) : 1;
  localparam int BI_W  = (MAX_BUNDLES > 1) ? $clog2(MAX_BUNDLES) : 1;
  localparam int CNT_W = $clog2(MAX_BUNDLES + 1);

  localparam int COST_W     = 28;
  localparam int PRICE_W    = 20;
  localparam int SIZE_W     = 8;
  localparam int QTY_W      = 8;
  localparam int IDX_W      = 5;
  localparam int COUNT_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int S_TDATA_W  = 48;
  localparam int M_TDATA_W  = 32;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_ITEM_COST    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCHEME_COUNT = 2'd1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QSTART,
    ST_FINIT,
    ST_FSCAN,
    ST_FDRAIN,
    ST_FWRITE,
    ST_QINIT,
    ST_QSCAN,
    ST_QDRAIN,
    ST_QOUT
  } step_e;

  typedef enum logic [1:0] {
    BEST_HOLD,
    BEST_UNIT,
    BEST_MAX
  } best_op_e;

  typedef enum logic [2:0] {
    C_NONE,
    C_START,
    C_VALID,
    C_SCHEME_MORE,
    C_QUERY_MORE,
    C_LAST_N,
    C_OUT_BUSY
  } cond_e;

  // one control word
  typedef struct packed {
    logic     mem_we;
    logic     wr_best;
    best_op_e best_op;
    logic     issue_fill;
    logic     issue_query;
    logic     n_clr;
    logic     n_inc;
    logic     i_clr;
    logic     i_inc;
    logic     m_load;
    logic     m_inc;
    logic     set_valid;
    logic     out_load;
    cond_e    cond;
    step_e    jump_to;
    step_e    next;
  } uop_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic start;
    logic table_valid;
    logic scheme_more;
    logic query_more;
    logic last_n;
    logic out_busy;
  } stat_t;

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [PRICE_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + (COST_W + 1)'(b);
    return (s > {1'b0, COST_MAX}) ? COST_MAX : s[COST_W-1:0];
  endfunction

  function automatic logic [COST_W-1:0] sat_add_cost(input logic [COST_W-1:0] a,
                                                     input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, COST_MAX}) ? COST_MAX : s[COST_W-1:0];
  endfunction

  // microcode ROM
  function automatic uop_t uop_rom(input step_e s);
    uop_t u;
    u = '0;
    u.best_op = BEST_HOLD;
    u.cond    = C_NONE;
    u.jump_to = ST_IDLE;
    u.next    = ST_IDLE;
    case (s)
      ST_IDLE: begin
        u.cond    = C_START;
        u.jump_to = ST_QSTART;
        u.next    = ST_IDLE;
      end
      ST_QSTART: begin
        u.n_clr   = 1'b1;
        u.cond    = C_VALID;
        u.jump_to = ST_QINIT;
        u.next    = ST_FINIT;
      end
      ST_FINIT: begin
        // cost of zero items, then base of entry one
        u.mem_we  = 1'b1;
        u.best_op = BEST_UNIT;
        u.n_inc   = 1'b1;
        u.i_clr   = 1'b1;
        u.jump_to = ST_FSCAN;
        u.next    = ST_FSCAN;
      end
      ST_FSCAN: begin
        u.issue_fill = 1'b1;
        u.i_inc      = 1'b1;
        u.cond       = C_SCHEME_MORE;
        u.jump_to    = ST_FSCAN;
        u.next       = ST_FDRAIN;
      end
      ST_FDRAIN: begin
        u.jump_to = ST_FWRITE;
        u.next    = ST_FWRITE;
      end
      ST_FWRITE: begin
        u.mem_we  = 1'b1;
        u.wr_best = 1'b1;
        u.best_op = BEST_UNIT;
        u.n_inc   = 1'b1;
        u.i_clr   = 1'b1;
        u.cond    = C_LAST_N;
        u.jump_to = ST_QINIT;
        u.next    = ST_FSCAN;
      end
      ST_QINIT: begin
        u.best_op   = BEST_MAX;
        u.m_load    = 1'b1;
        u.set_valid = 1'b1;
        u.jump_to   = ST_QSCAN;
        u.next      = ST_QSCAN;
      end
      ST_QSCAN: begin
        u.issue_query = 1'b1;
        u.m_inc       = 1'b1;
        u.cond        = C_QUERY_MORE;
        u.jump_to     = ST_QSCAN;
        u.next        = ST_QDRAIN;
      end
      ST_QDRAIN: begin
        u.jump_to = ST_QOUT;
        u.next    = ST_QOUT;
      end
      ST_QOUT: begin
        u.out_load = 1'b1;
        u.cond     = C_OUT_BUSY;
        u.jump_to  = ST_QOUT;
        u.next     = ST_IDLE;
      end
      default: begin
        u.next = ST_IDLE;
      end
    endcase
    return u;
  endfunction

endpackage

FILE: hdl/mccq_cost_ram.sv
// Cost table storage: one write port, one read port, registered read data.
// Depends on mccq_pkg for depth and widths.
module mccq_cost_ram (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [mccq_pkg::QA_W-1:0]    waddr_i,
  input  logic [mccq_pkg::COST_W-1:0]  wdata_i,
  input  logic [mccq_pkg::QA_W-1:0]    raddr_i,
  output logic [mccq_pkg::COST_W-1:0]  rdata_o
);
  import mccq_pkg::*;

  logic [COST_W-1:0] mem [QUANTITY_LIMIT];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: hdl/mccq_useq.sv
// Microcode sequencer: step register, ROM lookup and conditional jump.
// Depends on mccq_pkg for the ROM, step and flag types.
module mccq_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mccq_pkg::stat_t stat_i,
  output mccq_pkg::step_e step_o,
  output mccq_pkg::uop_t  uop_o
);
  import mccq_pkg::*;

  step_e step_q, step_d;
  logic  taken;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  always_comb begin
    uop_o = uop_rom(step_q);
    case (uop_o.cond)
      C_NONE:        taken = 1'b0;
      C_START:       taken = stat_i.start;
      C_VALID:       taken = stat_i.table_valid;
      C_SCHEME_MORE: taken = stat_i.scheme_more;
      C_QUERY_MORE:  taken = stat_i.query_more;
      C_LAST_N:      taken = stat_i.last_n;
      C_OUT_BUSY:    taken = stat_i.out_busy;
      default:       taken = 1'b0;
    endcase
    step_d = taken ? uop_o.jump_to : uop_o.next;
  end

  assign step_o = step_q;

endmodule

FILE: hdl/min_cost_cover_quantity_dp.sv
// Top level of the min-cost cover block: stream ports, config, datapath.
// Depends on mccq_pkg, mccq_useq and mccq_cost_ram.
//
// Least cost of buying at least a wanted quantity, from single items at
// the single-item price and any number of bundles from up to MAX_BUNDLES
// stored schemes. A load transfer (tuser 0) writes one scheme slot and marks
// the cost table stale; it produces no result and the input is ready again
// on the next cycle. A query transfer (tuser 1) returns one result. If the
// table is stale it is first refilled, then the suffix minimum is taken.
// The refill and the suffix minimum are both paced by the single read port
// of the cost table: one candidate or one table entry per cycle, through a
// two-stage read/compare pipe. A control ROM steps the datapath; input is
// ready only between queries, while the result register holds the last
// result until taken.
// Writes on the config port also mark the table stale and must come while
// the block is idle.
module min_cost_cover_quantity_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write port
  input  logic                               cfg_we_i,
  input  logic [mccq_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mccq_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // scheme_index[4:0], scheme_size[12:5], scheme_price[32:13],
  // quantity[40:33], zero pad
  input  logic [mccq_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // operation[0]
  input  logic                               s_axis_tuser,
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // total_cost[27:0], zero pad
  output logic [mccq_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // saturated[0]
  output logic                               m_axis_tuser
);
  import mccq_pkg::*;

  // input fields
  logic [IDX_W-1:0]   in_idx;
  logic [SIZE_W-1:0]  in_size;
  logic [PRICE_W-1:0] in_price;
  logic [QTY_W-1:0]   in_qty;

  assign in_idx   = s_axis_tdata[4:0];
  assign in_size  = s_axis_tdata[12:5];
  assign in_price = s_axis_tdata[32:13];
  assign in_qty   = s_axis_tdata[40:33];

  // sequencer
  step_e step;
  uop_t  uop;
  stat_t stat;

  mccq_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .step_o (step),
    .uop_o  (uop)
  );

  logic in_xfer, out_xfer, load_xfer;
  assign s_axis_tready = (step == ST_IDLE);
  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_xfer  = m_axis_tvalid && m_axis_tready;
  assign load_xfer = in_xfer && (s_axis_tuser == OP_LOAD) && (int'(in_idx) < MAX_BUNDLES);

  // config registers and table status
  logic [PRICE_W-1:0] item_cost_q;
  logic [COUNT_W-1:0] scheme_count_q;
  logic               valid_q;
  logic [CNT_W-1:0]   used;

  assign used = (int'(scheme_count_q) > MAX_BUNDLES) ? CNT_W'(MAX_BUNDLES)
                                                     : CNT_W'(scheme_count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_cost_q    <= '0;
      scheme_count_q <= '0;
      valid_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ITEM_COST: begin
            item_cost_q <= cfg_wdata_i[PRICE_W-1:0];
            valid_q     <= 1'b0;
          end
          REG_SCHEME_COUNT: begin
            scheme_count_q <= cfg_wdata_i[COUNT_W-1:0];
            valid_q        <= 1'b0;
          end
          default: ;
        endcase
      end
      if (load_xfer) begin
        valid_q <= 1'b0;
      end
      if (uop.set_valid) begin
        valid_q <= 1'b1;
      end
    end
  end

  // scheme slots, undefined until written
  logic [SIZE_W-1:0]  size_mem  [MAX_BUNDLES];
  logic [PRICE_W-1:0] price_mem [MAX_BUNDLES];

  always_ff @(posedge clk_i) begin
    if (load_xfer) begin
      size_mem[BI_W'(in_idx)]  <= in_size;
      price_mem[BI_W'(in_idx)] <= in_price;
    end
  end

  // counters: n = entry being filled, i = scheme, m = suffix scan position
  logic [QA_W-1:0] n_q, m_q, q_q;
  logic [BI_W-1:0] i_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
      m_q <= '0;
      q_q <= '0;
      i_q <= '0;
    end else begin
      if (in_xfer) begin
        // quantity past the table end reads the last entry
        q_q <= (int'(in_qty) >= QUANTITY_LIMIT) ? QA_W'(QUANTITY_LIMIT - 1)
                                                : QA_W'(in_qty);
      end
      if (uop.n_clr) begin
        n_q <= '0;
      end else if (uop.n_inc) begin
        n_q <= n_q + 1'b1;
      end
      if (uop.i_clr) begin
        i_q <= '0;
      end else if (uop.i_inc) begin
        i_q <= i_q + 1'b1;
      end
      if (uop.m_load) begin
        m_q <= q_q;
      end else if (uop.m_inc) begin
        m_q <= m_q + 1'b1;
      end
    end
  end

  // stage 1: scheme lookup and cost table read
  logic [SIZE_W-1:0]  sch_size;
  logic [PRICE_W-1:0] sch_price;
  logic               fill_ok;
  logic [QA_W-1:0]    rd_addr;
  logic [COST_W-1:0]  wr_data;
  logic [COST_W-1:0]  rd_data;
  logic [COST_W-1:0]  best_q, best_d;

  assign sch_size  = size_mem[i_q];
  assign sch_price = price_mem[i_q];
  // zero-size bundles and bundles larger than n are skipped
  assign fill_ok = (int'(i_q) < int'(used)) && (sch_size != '0) &&
                   (int'(sch_size) <= int'(n_q));
  assign rd_addr = uop.issue_query ? m_q : (n_q - QA_W'(sch_size));
  assign wr_data = uop.wr_best ? best_q : '0;

  mccq_cost_ram u_cost_ram (
    .clk_i   (clk_i),
    .we_i    (uop.mem_we),
    .waddr_i (n_q),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  logic               pvld_q, padd_q;
  logic [PRICE_W-1:0] pprice_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= 1'b0;
      padd_q <= 1'b0;
    end else begin
      pvld_q <= (uop.issue_fill && fill_ok) || uop.issue_query;
      padd_q <= uop.issue_fill;
    end
  end

  always_ff @(posedge clk_i) begin
    pprice_q <= sch_price;
  end

  // stage 2: candidate and running minimum
  logic [COST_W-1:0] cand;
  assign cand = padd_q ? sat_add(rd_data, pprice_q) : rd_data;

  always_comb begin
    best_d = best_q;
    case (uop.best_op)
      BEST_UNIT: best_d = sat_add(wr_data, item_cost_q);
      BEST_MAX:  best_d = COST_MAX;
      BEST_HOLD: begin
        if (pvld_q && (cand < best_q)) begin
          best_d = cand;
        end
      end
      default: best_d = best_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
  end

  // result register
  logic              out_valid_q;
  logic [COST_W-1:0] out_cost_q;
  logic              out_sat_q;
  logic              out_load;

  assign out_load = uop.out_load && !stat.out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cost_q <= best_q;
      out_sat_q  <= (best_q == COST_MAX);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W - COST_W){1'b0}}, out_cost_q};
  assign m_axis_tuser  = out_sat_q;

  // flags for the sequencer
  always_comb begin
    stat.start       = in_xfer && (s_axis_tuser == OP_QUERY);
    stat.table_valid = valid_q;
    stat.scheme_more = (int'(i_q) + 1) < int'(used);
    stat.query_more  = (m_q != QA_W'(QUANTITY_LIMIT - 1));
    stat.last_n      = (n_q == QA_W'(QUANTITY_LIMIT - 1));
    stat.out_busy    = out_valid_q && !m_axis_tready;
  end

endmodule

FILE: hdl/mccq_checker.sv
// Port-level checks of the min-cost cover block, bound to its top level.
// Depends on mccq_pkg and min_cost_cover_quantity_dp.
module mccq_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               s_axis_tuser,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [mccq_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  input logic                               m_axis_tuser
);
  import mccq_pkg::*;

  // saturation flag matches the cost field
  a_sat_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[COST_W-1:0] == COST_MAX)))
    else $error("saturated flag disagrees with total_cost");

  // a query transfer occupies the block
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_QUERY) |=> !s_axis_tready)
    else $error("input ready right after a query transfer");

  // a load transfer leaves the input ready on the next cycle
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_LOAD) |=> s_axis_tready)
    else $error("input not ready after a load transfer");

  // a new result only comes out of query work
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while the block was idle");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind min_cost_cover_quantity_dp mccq_checker u_mccq_checker (.*);
